FILE: hdl/pbs_pkg.sv
// Package with the beat types, codes and sizes shared by the palette block store.
`default_nettype none
package pbs_pkg;

  localparam int unsigned PAL_BITS_DEF = 4;
  localparam int unsigned KEY_W        = 32;
  localparam int unsigned COORD_W      = 8;
  localparam int unsigned ID_W         = 4;
  localparam int unsigned CNT_W        = 5;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned AXIS_W       = 4;
  localparam int unsigned CELL_AW      = 3 * AXIS_W;
  localparam int unsigned CELL_COUNT   = 16 * 16 * 16;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_COORD = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic               cmd;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [KEY_W-1:0]   key;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    read_key;
    logic [ID_W-1:0]     palette_id;
    logic [CNT_W-1:0]    palette_count;
  } out_item_t;

  typedef struct packed {
    logic clear;
    logic accept;
    logic exec;
  } pbs_cmd_t;

  typedef struct packed {
    logic clear_last;
  } pbs_sts_t;

endpackage
`default_nettype wire

FILE: hdl/pbs_ctrl.sv
// Controller state machine: clearing pass after reset, then accept and execute of each beat.
`default_nettype none
module pbs_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire pbs_pkg::pbs_sts_t sts,
  output pbs_pkg::pbs_cmd_t      cmd,
  output logic                   busy
);
  import pbs_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (sts.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy       = (state_r != ST_IDLE);
  assign cmd.clear  = (state_r == ST_CLEAR);
  assign cmd.accept = (state_r == ST_IDLE) && start;
  assign cmd.exec   = (state_r == ST_EXEC);

endmodule
`default_nettype wire

FILE: hdl/pbs_datapath.sv
// Datapath: palette registers, cell id memory, key match and result register.
`default_nettype none
module pbs_datapath #(
  parameter int unsigned PAL_BITS = pbs_pkg::PAL_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pbs_pkg::pbs_cmd_t cmd,
  input  wire pbs_pkg::in_item_t in_data,
  output pbs_pkg::pbs_sts_t      sts,
  output logic                   out_valid,
  output pbs_pkg::out_item_t     out_data
);
  import pbs_pkg::*;

  localparam int unsigned CAP  = 1 << PAL_BITS;
  localparam int unsigned UW   = PAL_BITS + 1;
  localparam logic [UW-1:0] CAP_U = UW'(CAP);

  logic [PAL_BITS-1:0]     mem [CELL_COUNT];
  logic [PAL_BITS-1:0]     rdata_r;
  logic [KEY_W-1:0]        keys_r [CAP];
  logic [UW-1:0]           used_r;
  logic [UW-1:0]           used_nxt;
  logic [CELL_AW-1:0]      clr_cnt_r;
  in_item_t                item_r;
  out_item_t               out_r;
  out_item_t               out_nxt;
  logic                    out_valid_r;

  logic                    coord_ok;
  logic [CELL_AW-1:0]      cell_idx;
  logic [CELL_AW-1:0]      rd_idx;
  logic [CAP-1:0]          hit;
  logic                    found;
  logic [PAL_BITS-1:0]     hit_id;
  logic                    full;
  logic                    append;
  logic                    cell_we;
  logic [CELL_AW-1:0]      waddr;
  logic [PAL_BITS-1:0]     wdata;
  logic [PAL_BITS-1:0]     wr_id;
  logic [KEY_W-1:0]        rd_key;

  assign coord_ok = (item_r.x[COORD_W-1:AXIS_W] == '0) &&
                    (item_r.y[COORD_W-1:AXIS_W] == '0) &&
                    (item_r.z[COORD_W-1:AXIS_W] == '0);
  assign cell_idx = {item_r.y[AXIS_W-1:0], item_r.z[AXIS_W-1:0], item_r.x[AXIS_W-1:0]};
  assign rd_idx   = {in_data.y[AXIS_W-1:0], in_data.z[AXIS_W-1:0], in_data.x[AXIS_W-1:0]};

  always_comb begin
    for (int i = 0; i < CAP; i++) begin
      hit[i] = (UW'(i) < used_r) && (keys_r[i] == item_r.key);
    end
  end

  always_comb begin
    hit_id = '0;
    for (int i = CAP - 1; i >= 0; i--) begin
      if (hit[i]) hit_id = PAL_BITS'(i);
    end
  end

  assign found  = |hit;
  assign full   = (used_r == CAP_U);
  assign wr_id  = found ? hit_id : used_r[PAL_BITS-1:0];
  assign append = cmd.exec && (item_r.cmd == CMD_WRITE) && coord_ok && !found && !full;
  assign cell_we = cmd.clear ||
                   (cmd.exec && (item_r.cmd == CMD_WRITE) && coord_ok && (found || !full));
  assign waddr  = cmd.clear ? clr_cnt_r : cell_idx;
  assign wdata  = cmd.clear ? '0 : wr_id;
  assign used_nxt = append ? used_r + UW'(1) : used_r;

  assign rd_key = ({1'b0, rdata_r} < used_r) ? keys_r[rdata_r] : '0;

  always_comb begin
    out_nxt.status        = ST_OK;
    out_nxt.read_key      = '0;
    out_nxt.palette_id    = '0;
    out_nxt.palette_count = CNT_W'(used_nxt);
    if (!coord_ok) begin
      out_nxt.status = ST_BAD_COORD;
    end else if (item_r.cmd == CMD_READ) begin
      out_nxt.read_key   = rd_key;
      out_nxt.palette_id = ID_W'(rdata_r);
    end else if (found || !full) begin
      out_nxt.palette_id = ID_W'(wr_id);
    end else begin
      out_nxt.status = ST_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (cell_we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) rdata_r <= mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) item_r <= in_data;
    if (cmd.exec) out_r <= out_nxt;
    if (append) keys_r[used_r[PAL_BITS-1:0]] <= item_r.key;
    if (!rst_n) keys_r[0] <= '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= UW'(1);
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      used_r      <= used_nxt;
      out_valid_r <= cmd.exec;
      if (cmd.clear) clr_cnt_r <= clr_cnt_r + CELL_AW'(1);
    end
  end

  assign sts.clear_last = &clr_cnt_r;
  assign out_valid      = out_valid_r;
  assign out_data       = out_r;

endmodule
`default_nettype wire

FILE: hdl/palette_block_store.sv
// Top level of the palette block store: controller and datapath joined by command and status.
//
// A 16x16x16 store of palette ids with a palette of up to 2^PAL_BITS state keys.
// Input channel: a beat in in_data is taken at a rising edge where start is high and
// busy is low. A write looks the key up in the palette, appends it if absent and room
// remains, and stores the id at the cell; a read returns the key of the cell's id.
// Result channel: out_valid is high for exactly one cycle with the result in out_data.
// The receiver cannot stall; every result must be taken in the cycle it is shown.
// The cell memory read happens at accept; the palette match plus memory write happen in the
// execute state, whose result is registered. Busy stays high in execute, so a new beat is
// not taken before the last one is through.
// Reset: synchronous, active low. The palette then holds only air at id 0, and a
// clearing pass writes air to all 4096 cells, one per cycle, with busy held high for
// the whole pass before the first beat can be taken.
// Coordinates above 15 return status 1; a write of a new key to a full palette
// returns status 2 and changes nothing.
`default_nettype none
module palette_block_store #(
  parameter int unsigned PAL_BITS = pbs_pkg::PAL_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire pbs_pkg::in_item_t in_data,
  output logic                   out_valid,
  output pbs_pkg::out_item_t     out_data
);
  import pbs_pkg::*;

  pbs_cmd_t cmd;
  pbs_sts_t sts;

  pbs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  pbs_datapath #(
    .PAL_BITS (PAL_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
